### rtl/core/dxc_pkg.sv
// Shared types, constants and the word transform of the delta/xor codec.
package dxc_pkg;

   localparam int unsigned WORD_W             = 32;
   localparam int unsigned TILE_SIDE_DEFAULT  = 4;
   localparam int unsigned TILE_SIDE_MAX      = 8;
   localparam int unsigned TILE_WORDS_DEFAULT = TILE_SIDE_DEFAULT * TILE_SIDE_DEFAULT;
   localparam int unsigned COUNT_W            = $clog2(TILE_SIDE_MAX * TILE_SIDE_MAX + 1);
   localparam int unsigned QUEUE_DEPTH        = 2;
   localparam int unsigned OUT_DEPTH          = 4;
   localparam int unsigned CSR_INDEX_W        = 2;
   localparam int unsigned CSR_DATA_W         = 2;

   localparam logic DIR_ENCODE    = 1'b0;
   localparam logic DIR_DECODE    = 1'b1;
   localparam logic LAYOUT_LINEAR = 1'b0;
   localparam logic LAYOUT_TILE   = 1'b1;

   localparam logic [1:0] POS_FIRST     = 2'd0;
   localparam logic [1:0] POS_SECOND    = 2'd1;
   localparam logic [1:0] POS_SATURATED = 2'd2;

   typedef enum logic [1:0] {
      KIND_DIFF  = 2'd0,
      KIND_DIFF2 = 2'd1,
      KIND_XOR   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRANSFORM_KIND = 2'd0,
      CSR_DIRECTION      = 2'd1,
      CSR_TILE_LAYOUT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       dir;
      logic       layout;
   } cfg_type;

   // one queued job: a linear word, or a finished (possibly partial) tile
   typedef struct packed {
      logic               is_tile;
      logic [WORD_W-1:0]  word;
      logic               last;
      logic               full;
      logic [COUNT_W-1:0] count;
      logic               bank;
   } op_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

   function automatic logic [WORD_W-1:0] apply_word(
      input logic [WORD_W-1:0] x,
      input logic [WORD_W-1:0] h1,
      input logic [WORD_W-1:0] h2,
      input logic [1:0]        pos,
      input logic [1:0]        kind,
      input logic              dir
   );
      logic [WORD_W-1:0] r;
      logic [WORD_W-1:0] two_h1;
      two_h1 = {h1[WORD_W-2:0], 1'b0};
      if (pos == POS_FIRST) begin
         r = x;
      end else begin
         case (kind_type'(kind))
            KIND_XOR: begin
               r = x ^ h1;
            end
            KIND_DIFF2: begin
               if (pos == POS_SECOND) begin
                  r = (dir == DIR_DECODE) ? x + h1 : x - h1;
               end else begin
                  r = (dir == DIR_DECODE) ? x + two_h1 - h2 : x - two_h1 + h2;
               end
            end
            default: begin
               // the unused code behaves as plain difference
               r = (dir == DIR_DECODE) ? x + h1 : x - h1;
            end
         endcase
      end
      return r;
   endfunction

endpackage

### rtl/core/dxc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dxc_ram #(
   parameter int unsigned WIDTH = dxc_pkg::WORD_W,
   parameter int unsigned DEPTH = dxc_pkg::TILE_WORDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dxc_op_queue.sv
// Short job queue between the front (intake) and the back (execution).
module dxc_op_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dxc_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output dxc_pkg::op_type head_op
);

   localparam int unsigned PTR_W = $clog2(dxc_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(dxc_pkg::QUEUE_DEPTH + 1);

   dxc_pkg::op_type  slot_ff [dxc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(dxc_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(dxc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(dxc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### rtl/core/dxc_front.sv
// Intake: takes items, gathers tile words into a double-buffered store, queues jobs.
module dxc_front #(
   parameter int unsigned TILE_SIDE = dxc_pkg::TILE_SIDE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dxc_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [dxc_pkg::WORD_W-1:0] req_word_in,
   input  logic                      req_last_in,
   input  logic                      queue_full,
   output logic                      queue_push,
   output dxc_pkg::op_type           queue_op,
   input  dxc_pkg::bank_release_type release_in,
   output logic                      store_wr_en,
   output logic [$clog2(TILE_SIDE*TILE_SIDE):0] store_wr_addr,
   output logic [dxc_pkg::WORD_W-1:0] store_wr_data
);

   localparam int unsigned TILE_WORDS = TILE_SIDE * TILE_SIDE;
   localparam int unsigned IDX_W      = $clog2(TILE_WORDS);
   localparam int unsigned FILL_W     = $clog2(TILE_WORDS + 1);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              tile_mode;
   logic              accept;
   logic [FILL_W-1:0] fill_next;
   logic              tile_full;
   logic              tile_end;

   assign tile_mode = (cfg.layout == dxc_pkg::LAYOUT_TILE);
   assign fill_next = fill_ff + 1'b1;
   assign tile_full = (fill_next == FILL_W'(TILE_WORDS));
   assign tile_end  = tile_full || req_last_in;

   // a tile word needs its bank free of the job the back is still reading
   assign req_ready = !queue_full && (!tile_mode || !busy_ff[bank_ff]);
   assign accept    = req_valid && req_ready;

   assign queue_push       = accept && (!tile_mode || tile_end);
   assign queue_op.is_tile = tile_mode;
   assign queue_op.word    = req_word_in;
   assign queue_op.last    = req_last_in;
   assign queue_op.full    = tile_full;
   assign queue_op.count   = dxc_pkg::COUNT_W'(fill_next);
   assign queue_op.bank    = bank_ff;

   assign store_wr_en   = accept && tile_mode;
   assign store_wr_addr = {bank_ff, fill_ff[IDX_W-1:0]};
   assign store_wr_data = req_word_in;

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (release_in.valid) begin
         busy_in[release_in.bank] = 1'b0;
      end
      if (accept && tile_mode) begin
         if (tile_end) begin
            // hand the bank to the back, flip to the other one
            busy_in[bank_ff] = 1'b1;
            bank_in          = !bank_ff;
            fill_in          = '0;
         end else begin
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

### rtl/core/dxc_back.sv
// Execution: runs queued jobs through the transform and buffers the result items.
module dxc_back #(
   parameter int unsigned TILE_SIDE = dxc_pkg::TILE_SIDE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dxc_pkg::cfg_type           cfg,
   input  logic                       queue_valid,
   input  dxc_pkg::op_type            queue_head,
   output logic                       queue_pop,
   output dxc_pkg::bank_release_type  release_out,
   output logic                       store_rd_en,
   output logic [$clog2(TILE_SIDE*TILE_SIDE):0] store_rd_addr,
   input  logic [dxc_pkg::WORD_W-1:0] store_rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [dxc_pkg::WORD_W-1:0] rsp_word_out,
   output logic                       rsp_last_out
);

   localparam int unsigned TILE_WORDS = TILE_SIDE * TILE_SIDE;
   localparam int unsigned IDX_W      = $clog2(TILE_WORDS);
   localparam int unsigned CNT_W      = IDX_W + 1;
   localparam int unsigned SIDE_W     = $clog2(TILE_SIDE);
   localparam int unsigned OUT_PTR_W  = $clog2(dxc_pkg::OUT_DEPTH);
   localparam int unsigned OUT_CNT_W  = $clog2(dxc_pkg::OUT_DEPTH + 1);
   localparam int unsigned W          = dxc_pkg::WORD_W;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_RUN      = 4'b0010,
      ST_ENC_PASS = 4'b0100,
      ST_ENC_EMIT = 4'b1000
   } back_state_type;

   typedef enum logic [1:0] {
      SRC_LINEAR = 2'd0,
      SRC_APPLY  = 2'd1,
      SRC_STORE  = 2'd2,
      SRC_RAW    = 2'd3
   } src_type;

   back_state_type state_ff, state_in;

   logic              op_last_ff, op_last_in;
   logic              op_bank_ff, op_bank_in;
   logic              op_xpose_ff, op_xpose_in;
   logic [CNT_W-1:0]  op_count_ff, op_count_in;

   logic [IDX_W-1:0]  k_ff, k_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0]  sw_ff, sw_in;

   logic              p1_valid_ff, p1_valid_in;
   src_type           p1_src_ff, p1_src_in;
   logic [W-1:0]      p1_word_ff, p1_word_in;
   logic              p1_last_ff, p1_last_in;
   logic [IDX_W-1:0]  p1_idx_ff, p1_idx_in;

   logic [W-1:0]      h1_ff, h1_in;
   logic [W-1:0]      h2_ff, h2_in;
   logic [1:0]        pos_ff, pos_in;

   logic [W-1:0]      out_word_ff [dxc_pkg::OUT_DEPTH];
   logic              out_last_ff [dxc_pkg::OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   logic              p1_push;
   logic              credit_ok;
   logic              store_pending;
   logic              final_step;
   logic              step;

   logic              enc_rd_en;
   logic              enc_wr_en;
   logic [W-1:0]      enc_rd_data;
   logic [W-1:0]      x;
   logic [W-1:0]      r;
   logic [W-1:0]      out_word;
   logic              rsp_pop;

   dxc_ram #(
      .WIDTH (W),
      .DEPTH (TILE_WORDS)
   ) u_enc_buf (
      .clock   (clock),
      .wr_en   (enc_wr_en),
      .wr_addr (p1_idx_ff),
      .wr_data (r),
      .rd_en   (enc_rd_en),
      .rd_addr (sw_ff),
      .rd_data (enc_rd_data)
   );

   assign p1_push       = p1_valid_ff && (p1_src_ff != SRC_STORE);
   assign store_pending = p1_valid_ff && (p1_src_ff == SRC_STORE);
   // keep room for the item in flight plus the one issued now
   assign credit_ok     = (out_cnt_ff + OUT_CNT_W'(p1_push))
                          <= OUT_CNT_W'(dxc_pkg::OUT_DEPTH - 2);
   assign final_step    = ({1'b0, k_ff} == (op_count_ff - CNT_W'(1)));

   // issue side: walk the job and launch one word per cycle; emitting steps wait while the result buffer lacks room
   always_comb begin
      state_in      = state_ff;
      op_last_in    = op_last_ff;
      op_bank_in    = op_bank_ff;
      op_xpose_in   = op_xpose_ff;
      op_count_in   = op_count_ff;
      queue_pop     = 1'b0;
      release_out   = '0;
      store_rd_en   = 1'b0;
      store_rd_addr = {op_bank_ff, k_ff};
      enc_rd_en     = 1'b0;
      step          = 1'b0;
      p1_valid_in   = 1'b0;
      p1_src_in     = SRC_APPLY;
      p1_word_in    = queue_head.word;
      p1_last_in    = op_last_ff && final_step;
      p1_idx_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               if (!queue_head.is_tile) begin
                  if (credit_ok) begin
                     queue_pop   = 1'b1;
                     p1_valid_in = 1'b1;
                     p1_src_in   = SRC_LINEAR;
                     p1_last_in  = queue_head.last;
                  end
               end else begin
                  queue_pop   = 1'b1;
                  op_last_in  = queue_head.last;
                  op_bank_in  = queue_head.bank;
                  op_count_in = queue_head.count[CNT_W-1:0];
                  op_xpose_in = queue_head.full;
                  if (queue_head.full && (cfg.dir == dxc_pkg::DIR_ENCODE)) begin
                     state_in = ST_ENC_PASS;
                  end else begin
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            if (credit_ok) begin
               store_rd_en   = 1'b1;
               store_rd_addr = {op_bank_ff, op_xpose_ff ? sw_ff : k_ff};
               p1_valid_in   = 1'b1;
               p1_src_in     = SRC_APPLY;
               step          = 1'b1;
               if (final_step) begin
                  release_out.valid = 1'b1;
                  release_out.bank  = op_bank_ff;
                  state_in          = ST_IDLE;
               end
            end
         end
         ST_ENC_PASS: begin
            // encode in arrival order into the staging buffer
            store_rd_en = 1'b1;
            p1_valid_in = 1'b1;
            p1_src_in   = SRC_STORE;
            step        = 1'b1;
            if (final_step) begin
               release_out.valid = 1'b1;
               release_out.bank  = op_bank_ff;
               state_in          = ST_ENC_EMIT;
            end
         end
         ST_ENC_EMIT: begin
            // wait for the last staging write before reading transposed
            if (credit_ok && !store_pending) begin
               enc_rd_en   = 1'b1;
               p1_valid_in = 1'b1;
               p1_src_in   = SRC_RAW;
               step        = 1'b1;
               if (final_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // position counters; sw tracks the transposed index col*side + row
   always_comb begin
      k_in   = k_ff;
      row_in = row_ff;
      col_in = col_ff;
      sw_in  = sw_ff;
      if (step) begin
         if (final_step) begin
            k_in   = '0;
            row_in = '0;
            col_in = '0;
            sw_in  = '0;
         end else begin
            k_in = k_ff + 1'b1;
            if (col_ff == SIDE_W'(TILE_SIDE - 1)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
               sw_in  = IDX_W'(row_ff) + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
               sw_in  = sw_ff + IDX_W'(TILE_SIDE);
            end
         end
      end
   end

   // data side: transform and update the stream history
   assign x         = (p1_src_ff == SRC_LINEAR) ? p1_word_ff : store_rd_data;
   assign r         = dxc_pkg::apply_word(x, h1_ff, h2_ff, pos_ff, cfg.kind, cfg.dir);
   assign out_word  = (p1_src_ff == SRC_RAW) ? enc_rd_data : r;
   assign enc_wr_en = store_pending;

   always_comb begin
      h1_in  = h1_ff;
      h2_in  = h2_ff;
      pos_in = pos_ff;
      if (p1_valid_ff && (p1_src_ff != SRC_RAW)) begin
         if (p1_last_ff) begin
            h1_in  = '0;
            h2_in  = '0;
            pos_in = dxc_pkg::POS_FIRST;
         end else begin
            h2_in  = h1_ff;
            h1_in  = (cfg.dir == dxc_pkg::DIR_DECODE) ? r : x;
            pos_in = (pos_ff == dxc_pkg::POS_SATURATED) ? pos_ff : pos_ff + 2'd1;
         end
      end
   end

   // result buffer
   assign rsp_valid    = (out_cnt_ff != '0);
   assign rsp_word_out = out_word_ff[out_rd_ff];
   assign rsp_last_out = out_last_ff[out_rd_ff];
   assign rsp_pop      = rsp_valid && rsp_ready;

   always_comb begin
      out_wr_in  = p1_push ? out_wr_ff + 1'b1 : out_wr_ff;
      out_rd_in  = rsp_pop ? out_rd_ff + 1'b1 : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (p1_push && !rsp_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (rsp_pop && !p1_push) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         op_last_ff  <= 1'b0;
         op_bank_ff  <= 1'b0;
         op_xpose_ff <= 1'b0;
         op_count_ff <= '0;
         k_ff        <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         sw_ff       <= '0;
         p1_valid_ff <= 1'b0;
         h1_ff       <= '0;
         h2_ff       <= '0;
         pos_ff      <= dxc_pkg::POS_FIRST;
         out_wr_ff   <= '0;
         out_rd_ff   <= '0;
         out_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         op_last_ff  <= op_last_in;
         op_bank_ff  <= op_bank_in;
         op_xpose_ff <= op_xpose_in;
         op_count_ff <= op_count_in;
         k_ff        <= k_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         sw_ff       <= sw_in;
         p1_valid_ff <= p1_valid_in;
         h1_ff       <= h1_in;
         h2_ff       <= h2_in;
         pos_ff      <= pos_in;
         out_wr_ff   <= out_wr_in;
         out_rd_ff   <= out_rd_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_src_ff  <= p1_src_in;
      p1_word_ff <= p1_word_in;
      p1_last_ff <= p1_last_in;
      p1_idx_ff  <= p1_idx_in;
      if (p1_push) begin
         out_word_ff[out_wr_ff] <= out_word;
         out_last_ff[out_wr_ff] <= p1_last_ff;
      end
   end

endmodule

### rtl/core/delta_xor_codec_engine.sv
// Streaming delta / second-order delta / xor codec over 32-bit words, with
// optional transposed tile layout. In linear layout one item is taken and one
// result delivered per cycle while rsp_ready stays high, via the job queue,
// the p1 register stage and the result buffer. In tile layout a tile's words
// (TILE_SIDE*TILE_SIDE of them) are taken one per cycle, while their bank is
// free and the queue has room, into a double-buffered tile store, so the next
// tile can fill while the previous one drains; a decoded or partial tile is
// emitted one word per cycle while the result buffer has room, and a fully
// encoded tile is first encoded into a staging buffer, then emitted likewise.
// Configuration is for the user to write through the csr port while the block
// is idle (the block does not enforce this); it is used as jobs run.
module delta_xor_codec_engine #(
   parameter int unsigned TILE_SIDE = dxc_pkg::TILE_SIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dxc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dxc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dxc_pkg::WORD_W-1:0]        req_word_in,
   input  logic                              req_last_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dxc_pkg::WORD_W-1:0]        rsp_word_out,
   output logic                              rsp_last_out
);

   localparam int unsigned TILE_WORDS   = TILE_SIDE * TILE_SIDE;
   localparam int unsigned STORE_ADDR_W = $clog2(TILE_WORDS) + 1;

   dxc_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      queue_full;
   logic                      queue_push;
   logic                      queue_pop;
   logic                      queue_valid;
   dxc_pkg::op_type           queue_op;
   dxc_pkg::op_type           queue_head;
   dxc_pkg::bank_release_type bank_release;
   logic                      store_wr_en;
   logic [STORE_ADDR_W-1:0]   store_wr_addr;
   logic [dxc_pkg::WORD_W-1:0] store_wr_data;
   logic                      store_rd_en;
   logic [STORE_ADDR_W-1:0]   store_rd_addr;
   logic [dxc_pkg::WORD_W-1:0] store_rd_data;

   // register file: keep both bits of kind and only the low bit of direction and layout
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dxc_pkg::CSR_TRANSFORM_KIND: cfg_in.kind   = csr_wdata[1:0];
            dxc_pkg::CSR_DIRECTION:      cfg_in.dir    = csr_wdata[0];
            dxc_pkg::CSR_TILE_LAYOUT:    cfg_in.layout = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dxc_ram #(
      .WIDTH (dxc_pkg::WORD_W),
      .DEPTH (1 << STORE_ADDR_W)
   ) u_tile_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   dxc_front #(
      .TILE_SIDE (TILE_SIDE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word_in   (req_word_in),
      .req_last_in   (req_last_in),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_op      (queue_op),
      .release_in    (bank_release),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data)
   );

   dxc_op_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_op    (queue_op),
      .pop        (queue_pop),
      .full       (queue_full),
      .head_valid (queue_valid),
      .head_op    (queue_head)
   );

   dxc_back #(
      .TILE_SIDE (TILE_SIDE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .queue_valid   (queue_valid),
      .queue_head    (queue_head),
      .queue_pop     (queue_pop),
      .release_out   (bank_release),
      .store_rd_en   (store_rd_en),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word_out  (rsp_word_out),
      .rsp_last_out  (rsp_last_out)
   );

endmodule

### tb/sv/delta_xor_codec_engine_tb.sv
// Self-checking testbench for the delta/xor word codec, linear and tile layouts.
module delta_xor_codec_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SIDE        = dxc_pkg::TILE_SIDE_DEFAULT;
   localparam int unsigned TILE_N      = SIDE * SIDE;
   localparam int unsigned W           = dxc_pkg::WORD_W;
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned SETTLE      = 40;
   localparam int          ITEMS_TOTAL = 270;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam logic [1:0]  CSR_UNUSED  = 2'd3;

   typedef struct packed {
      logic [W-1:0] word;
      logic         last;
   } out_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [1:0]   csr_wdata = '0;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic [W-1:0] req_word_in = '0;
   logic         req_last_in = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [W-1:0] rsp_word_out;
   logic         rsp_last_out;

   // codec state as predicted
   logic [W-1:0] hist_one, hist_two;
   logic [1:0]   seen;
   logic [W-1:0] tile_buf [TILE_N];
   int           tile_count;
   logic [1:0]   cfg_kind;
   logic         cfg_dir, cfg_layout;

   out_word_type pending_words[$];

   int  error_count = 0;
   int  items_sent = 0;
   int  words_checked = 0;
   int  tiles_done = 0;
   int  phases = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  quiet_run = 1'b0;

   delta_xor_codec_engine dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word_in  (req_word_in),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_out (rsp_word_out),
      .rsp_last_out (rsp_last_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_history();
      hist_one = '0;
      hist_two = '0;
      seen = dxc_pkg::POS_FIRST;
   endfunction

   function automatic void reset_codec_state();
      cfg_kind = dxc_pkg::KIND_DIFF;
      cfg_dir = dxc_pkg::DIR_ENCODE;
      cfg_layout = dxc_pkg::LAYOUT_LINEAR;
      clear_history();
      tile_count = 0;
      foreach (tile_buf[k]) tile_buf[k] = '0;
   endfunction

   // element of the tile that lands at slot k once transposed
   function automatic int unsigned swap_slot(input int unsigned k);
      return (k % SIDE) * SIDE + k / SIDE;
   endfunction

   function automatic logic [W-1:0] transform_word(input logic [W-1:0] x);
      logic [W-1:0] r;
      logic [1:0]   kind;
      kind = (cfg_kind == KIND_UNUSED) ? dxc_pkg::KIND_DIFF : cfg_kind;
      if (seen == dxc_pkg::POS_FIRST) begin
         r = x;
      end else if (kind == dxc_pkg::KIND_XOR) begin
         r = x ^ hist_one;
      end else if (kind == dxc_pkg::KIND_DIFF || seen == dxc_pkg::POS_SECOND) begin
         r = (cfg_dir == dxc_pkg::DIR_DECODE) ? x + hist_one : x - hist_one;
      end else if (cfg_dir == dxc_pkg::DIR_DECODE) begin
         r = x + (hist_one + hist_one) - hist_two;
      end else begin
         r = x - (hist_one + hist_one) + hist_two;
      end
      hist_two = hist_one;
      hist_one = (cfg_dir == dxc_pkg::DIR_ENCODE) ? x : r;
      if (seen != dxc_pkg::POS_SATURATED) seen = seen + 2'd1;
      return r;
   endfunction

   function automatic void predict_item(input logic [W-1:0] x, input logic last);
      logic [W-1:0] enc [TILE_N];
      int           n;
      if (cfg_layout == dxc_pkg::LAYOUT_LINEAR) begin
         pending_words.push_back({transform_word(x), last});
         if (last) clear_history();
         return;
      end
      if (tile_count < TILE_N) tile_buf[tile_count] = x;
      tile_count++;
      if (tile_count >= TILE_N) begin
         n = TILE_N;
         if (cfg_dir == dxc_pkg::DIR_ENCODE) begin
            for (int k = 0; k < n; k++) enc[k] = transform_word(tile_buf[k]);
            for (int k = 0; k < n; k++)
               pending_words.push_back({enc[swap_slot(k)], (k == n - 1) ? last : 1'b0});
         end else begin
            for (int k = 0; k < n; k++)
               pending_words.push_back({transform_word(tile_buf[swap_slot(k)]),
                                        (k == n - 1) ? last : 1'b0});
         end
      end else if (last) begin
         // partial tile goes out in arrival order
         n = tile_count;
         for (int k = 0; k < n; k++)
            pending_words.push_back({transform_word(tile_buf[k]), (k == n - 1) ? last : 1'b0});
      end else begin
         return;
      end
      tile_count = 0;
      tiles_done++;
      if (last) clear_history();
   endfunction

   task automatic report_mismatch(input string what, input logic [W-1:0] want,
                                  input logic [W-1:0] got);
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      out_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected item", '0, rsp_word_out);
         end else begin
            want = pending_words.pop_front();
            if (rsp_word_out !== want.word) report_mismatch("word_out", want.word, rsp_word_out);
            if (rsp_last_out !== want.last)
               report_mismatch("last_out", {31'd0, want.last}, {31'd0, rsp_last_out});
         end
         words_checked++;
      end
   end

   // receiver: random stalls, a counted hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= quiet_run || ($urandom_range(0, 99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("delta_xor_codec_engine regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [W-1:0] word, input logic last);
      if (!quiet_run && $urandom_range(0, 99) < 19) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word_in <= word;
      req_last_in <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(word, last);
      items_sent++;
   endtask

   // drop valid, wait out all results, then let stored-only work settle
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         dxc_pkg::CSR_TRANSFORM_KIND: cfg_kind = value;
         dxc_pkg::CSR_DIRECTION:      cfg_dir = value[0];
         dxc_pkg::CSR_TILE_LAYOUT:    cfg_layout = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] kind, input logic dir, input logic layout);
      drain_block();
      write_register(dxc_pkg::CSR_TRANSFORM_KIND, kind);
      write_register(dxc_pkg::CSR_DIRECTION, {1'b0, dir});
      write_register(dxc_pkg::CSR_TILE_LAYOUT, {1'b0, layout});
      phases++;
   endtask

   function automatic logic [W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 15);
         3:       return 32'h8000_0000 ^ $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_stream(input int len, input bit close);
      for (int i = 0; i < len; i++) send_item(random_word(), close && (i == len - 1));
   endtask

   task automatic test_linear_extremes();
      configure(dxc_pkg::KIND_DIFF, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b1);
      configure(dxc_pkg::KIND_DIFF, dxc_pkg::DIR_DECODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b1);
   endtask

   task automatic test_transform_kinds();
      configure(dxc_pkg::KIND_DIFF2, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'd10, 1'b0);
      send_item(32'd3, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      configure(dxc_pkg::KIND_DIFF2, dxc_pkg::DIR_DECODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'd7, 1'b0);
      send_item(32'hFFFF_FFF0, 1'b0);
      send_item(32'h8000_0000, 1'b1);
      configure(dxc_pkg::KIND_XOR, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'hA5A5_A5A5, 1'b0);
      send_item(32'h5A5A_5A5A, 1'b1);
      configure(dxc_pkg::KIND_XOR, dxc_pkg::DIR_DECODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'h1234_5678, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      // unused kind code falls back to plain difference
      configure(KIND_UNUSED, dxc_pkg::DIR_DECODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'hFFFF_FFFE, 1'b0);
      send_item(32'd5, 1'b1);
   endtask

   task automatic test_register_quirks();
      configure(dxc_pkg::KIND_DIFF, dxc_pkg::DIR_DECODE, dxc_pkg::LAYOUT_LINEAR);
      drain_block();
      write_register(CSR_UNUSED, 2'b11);
      // only the low bit of direction and layout is kept
      write_register(dxc_pkg::CSR_DIRECTION, 2'b10);
      send_item(32'd100, 1'b0);
      send_item(32'd40, 1'b0);
      drain_block();
      write_register(dxc_pkg::CSR_TILE_LAYOUT, 2'b11);
      send_item(32'd1, 1'b0);
      send_item(32'd9, 1'b1);
   endtask

   task automatic test_mid_tile_switch();
      configure(dxc_pkg::KIND_DIFF, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_TILE);
      send_item(32'h0000_0010, 1'b0);
      send_item(32'h0000_0030, 1'b0);
      // stored words wait while linear words pass through
      configure(dxc_pkg::KIND_DIFF, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_LINEAR);
      send_item(32'h0000_0100, 1'b0);
      configure(dxc_pkg::KIND_DIFF, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_TILE);
      send_item(32'h0000_0005, 1'b1);
   endtask

   task automatic test_receiver_hold_off();
      configure(dxc_pkg::KIND_DIFF2, dxc_pkg::DIR_ENCODE, dxc_pkg::LAYOUT_TILE);
      hold_left = 250;
      send_stream(3 * TILE_N + 5, 1'b1);
      configure(dxc_pkg::KIND_XOR, dxc_pkg::DIR_DECODE, dxc_pkg::LAYOUT_TILE);
      hold_left = 120;
      send_stream(2 * TILE_N, 1'b1);
   endtask

   task automatic test_random_streams();
      int p, n, budget, len;
      logic [1:0] kind;
      logic dir, layout;
      p = 0;
      while (items_sent < ITEMS_TOTAL) begin
         case (p)
            0: begin
               kind = dxc_pkg::KIND_DIFF2; dir = dxc_pkg::DIR_DECODE;
               layout = dxc_pkg::LAYOUT_TILE;
            end
            1: begin
               kind = dxc_pkg::KIND_DIFF2; dir = dxc_pkg::DIR_ENCODE;
               layout = dxc_pkg::LAYOUT_TILE;
            end
            2: begin
               kind = dxc_pkg::KIND_XOR; dir = dxc_pkg::DIR_DECODE;
               layout = dxc_pkg::LAYOUT_LINEAR;
            end
            3: begin
               kind = KIND_UNUSED; dir = dxc_pkg::DIR_ENCODE;
               layout = dxc_pkg::LAYOUT_TILE;
            end
            default: begin
               kind = 2'($urandom_range(0, 3));
               dir = 1'($urandom_range(0, 1));
               layout = 1'($urandom_range(0, 1));
            end
         endcase
         configure(kind, dir, layout);
         quiet_run = (p == 2);
         budget = $urandom_range(20, 45);
         n = 0;
         while ((n < budget) && (items_sent < ITEMS_TOTAL)) begin
            if (layout == dxc_pkg::LAYOUT_TILE) begin
               case ($urandom_range(0, 3))
                  0:       len = $urandom_range(1, 5);
                  1:       len = TILE_N;
                  2:       len = 2 * TILE_N;
                  default: len = $urandom_range(TILE_N + 1, 40);
               endcase
            end else begin
               len = $urandom_range(1, 20);
            end
            if (len > budget - n) len = budget - n;
            if (len > ITEMS_TOTAL - items_sent) len = ITEMS_TOTAL - items_sent;
            // leave some streams open so history and stored words carry over
            send_stream(len, $urandom_range(0, 99) < 80);
            n += len;
         end
         p++;
      end
      quiet_run = 1'b0;
   endtask

   initial begin
      reset_codec_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_linear_extremes();
      test_transform_kinds();
      test_register_quirks();
      test_mid_tile_switch();
      test_receiver_hold_off();
      test_random_streams();

      drain_block();
      repeat (50) @(posedge clock);
      if (pending_words.size() != 0)
         report_mismatch("missing items", pending_words.size(), '0);
      $display("covered %0d items in and %0d words out over %0d register settings",
               items_sent, words_checked, phases);
      $display("%0d tiles or partial tiles emitted, %0d mismatches", tiles_done, error_count);
      if (error_count == 0) begin
         $display("delta_xor_codec_engine regression: pass");
      end else begin
         $display("delta_xor_codec_engine regression: fail");
      end
      $finish;
   end

endmodule
